// File: rtl/core/state_residency_profiler_unit_macros.svh
// assertion helpers for the profiler rtl
`ifndef STATE_RESIDENCY_PROFILER_UNIT_MACROS_SVH
`define STATE_RESIDENCY_PROFILER_UNIT_MACROS_SVH

// clocked check, quiet while reset is high
`define SRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define SRP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/srp_pkg.sv
`timescale 1ns / 1ps

package srp_pkg;

  // default sizing
  localparam int unsigned DEF_NUM_STATES = 16;
  localparam int unsigned DEF_TIME_BITS  = 48;
  localparam int unsigned DEF_COUNT_BITS = 32;

  // beat field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STATE_W = 5;
  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned STAMP_W = 48;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned DUR_W   = 48;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TRANSITION = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ       = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ_CLEAR = 2'd2;

  // interval type codes
  localparam logic [TYPE_W-1:0] TYPE_WAIT = 2'd1;

endpackage

// File: rtl/core/srp_item_if.sv
`timescale 1ns / 1ps

interface srp_item_if;
  import srp_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [STATE_W-1:0] new_state;
  logic [TYPE_W-1:0]  new_type;
  logic [STAMP_W-1:0] now;
  logic [INDEX_W-1:0] read_index;

  modport source (
    output valid, kind, new_state, new_type, now, read_index,
    input  ready
  );

  modport sink (
    input  valid, kind, new_state, new_type, now, read_index,
    output ready
  );
endinterface

// File: rtl/core/srp_result_if.sv
`timescale 1ns / 1ps

interface srp_result_if;
  import srp_pkg::*;

  logic               valid;
  logic               ready;
  logic               recorded;
  logic [INDEX_W-1:0] closed_state;
  logic               closed_type;
  logic [DUR_W-1:0]   duration;
  logic [COUNT_W-1:0] entry_compute_count;
  logic [DUR_W-1:0]   entry_compute_time;
  logic [COUNT_W-1:0] entry_wait_count;
  logic [DUR_W-1:0]   entry_wait_time;
  logic [INDEX_W-1:0] current_state;
  logic               current_type;

  modport source (
    output valid, recorded, closed_state, closed_type, duration,
           entry_compute_count, entry_compute_time, entry_wait_count,
           entry_wait_time, current_state, current_type,
    input  ready
  );

  modport sink (
    input  valid, recorded, closed_state, closed_type, duration,
           entry_compute_count, entry_compute_time, entry_wait_count,
           entry_wait_time, current_state, current_type,
    output ready
  );
endinterface

// File: rtl/core/srp_ram.sv
`timescale 1ns / 1ps

module srp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/state_residency_profiler_unit.sv
// The item is registered in stage 1 and then in the result register; a result beat that is
// not taken holds stage 1, so the result register loads only when stage 1 can advance.
// Throughput: one item per cycle while the result beat is not held; each item reads one row of
// the counter RAM in the accept cycle, and a record or clear item writes it back as it leaves stage 1.
// Reset: rst (synchronous) empties the pipeline, sets the active state to 1,
// type compute, interval start 0, and clears the per-row valid bits at once.
`timescale 1ns / 1ps
`include "state_residency_profiler_unit_macros.svh"

module state_residency_profiler_unit #(
  parameter int unsigned NUM_STATES = srp_pkg::DEF_NUM_STATES,
  parameter int unsigned TIME_BITS  = srp_pkg::DEF_TIME_BITS,
  parameter int unsigned COUNT_BITS = srp_pkg::DEF_COUNT_BITS
) (
  input logic         clk,
  input logic         rst,
  srp_item_if.sink    item,
  srp_result_if.source result
);
  import srp_pkg::*;

  localparam int unsigned IDXW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

  typedef logic [IDXW-1:0] idx_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  wait_time;
    logic [COUNT_BITS-1:0] wait_count;
    logic [TIME_BITS-1:0]  comp_time;
    logic [COUNT_BITS-1:0] comp_count;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RECORD,
    OP_HOLD,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                  op;
    idx_t                 addr;
    logic                 row_ok;
    logic                 row_live;
    logic [INDEX_W-1:0]   closed_state;
    logic                 closed_type;
    logic [TIME_BITS-1:0] dur;
    logic [INDEX_W-1:0]   cur_state;
    logic                 cur_type;
  } s1_t;

  // control and context registers
  idx_t                  active_state;
  logic                  active_type;
  logic [TIME_BITS-1:0]  interval_start;
  logic [NUM_STATES-1:0] vld;
  logic                  s1_v;
  s1_t                   s1;
  logic                  res_v;
  logic                  res_v_next;
  logic                  fw_v;
  idx_t                  fw_addr;
  entry_t                fw_data;

  // stage 0 signals
  s1_t                  s0;
  idx_t                 ns_n;
  logic                 nt_n;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] dur;
  logic                 changed;
  logic                 ri_ok;
  logic                 acc;
  logic                 s1_adv;

  // stage 1 signals
  entry_t                ram_rdata;
  entry_t                ram_wdata;
  logic                  ram_we;
  logic                  wr_req;
  logic                  hit;
  entry_t                cur;
  entry_t                upd;
  entry_t                report;
  logic [TIME_BITS-1:0]  sel_time;
  logic [COUNT_BITS-1:0] sel_count;
  logic                  tcarry;
  logic [TIME_BITS-1:0]  tsum;
  logic [TIME_BITS-1:0]  upd_time;
  logic [COUNT_BITS-1:0] upd_count;

  // handshakes
  assign s1_adv     = s1_v && (!res_v || result.ready);
  assign item.ready = !s1_v || s1_adv;
  assign acc        = item.valid && item.ready;
  assign res_v_next = s1_adv ? 1'b1 : (result.ready ? 1'b0 : res_v);

  // decode the item, close the interval timing, pick the row to read
  always_comb begin
    ns_n    = (32'(item.new_state) >= NUM_STATES) ? '0 : idx_t'(item.new_state);
    nt_n    = (item.new_type == TYPE_WAIT);
    now_t   = TIME_BITS'(item.now);
    changed = (ns_n != active_state) || (nt_n != active_type);
    dur     = (now_t >= interval_start) ? (now_t - interval_start) : '0;
    ri_ok   = 32'(item.read_index) < NUM_STATES;

    s0           = '0;
    s0.op        = OP_NONE;
    s0.cur_state = INDEX_W'(active_state);
    s0.cur_type  = active_type;
    unique case (item.kind)
      KIND_TRANSITION: begin
        s0.addr         = active_state;
        s0.row_ok       = 1'b1;
        s0.closed_state = INDEX_W'(active_state);
        s0.closed_type  = active_type;
        if (changed) begin
          s0.op        = OP_RECORD;
          s0.dur       = dur;
          s0.cur_state = INDEX_W'(ns_n);
          s0.cur_type  = nt_n;
        end else begin
          s0.op = OP_HOLD;
        end
      end
      KIND_READ, KIND_READ_CLEAR: begin
        s0.op           = (item.kind == KIND_READ) ? OP_READ : OP_CLEAR;
        s0.addr         = ri_ok ? idx_t'(item.read_index) : '0;
        s0.row_ok       = ri_ok;
        s0.closed_state = item.read_index;
      end
      default: begin
        s0.op = OP_NONE;
      end
    endcase
    s0.row_live = vld[s0.addr];
  end

  // row merge with forwarding of the write made at the read edge
  always_comb begin
    hit       = fw_v && (fw_addr == s1.addr);
    cur       = hit ? fw_data : (s1.row_live ? ram_rdata : '0);
    sel_time  = s1.closed_type ? cur.wait_time : cur.comp_time;
    sel_count = s1.closed_type ? cur.wait_count : cur.comp_count;
    {tcarry, tsum} = {1'b0, sel_time} + {1'b0, s1.dur};
    upd_time  = tcarry ? '1 : tsum;
    upd_count = (&sel_count) ? sel_count : sel_count + COUNT_BITS'(1);

    upd = cur;
    if (s1.closed_type) begin
      upd.wait_time  = upd_time;
      upd.wait_count = upd_count;
    end else begin
      upd.comp_time  = upd_time;
      upd.comp_count = upd_count;
    end
  end

  // per-op write-back and reported row
  always_comb begin
    wr_req    = 1'b0;
    ram_wdata = '0;
    report    = cur;
    unique case (s1.op)
      OP_RECORD: begin
        wr_req    = 1'b1;
        ram_wdata = upd;
        report    = upd;
      end
      OP_CLEAR: begin
        wr_req = s1.row_ok;
      end
      OP_HOLD, OP_READ: begin
        report = cur;
      end
      default: begin
        report = '0;
      end
    endcase
    if (!s1.row_ok) begin
      report = '0;
    end
  end

  assign ram_we = s1_adv && wr_req;

  srp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_STATES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1.addr),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (s0.addr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v           <= 1'b0;
      res_v          <= 1'b0;
      fw_v           <= 1'b0;
      vld            <= '0;
      active_state   <= idx_t'(1);
      active_type    <= 1'b0;
      interval_start <= '0;
    end else begin
      res_v <= res_v_next;
      if (acc) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (acc && (s0.op == OP_RECORD)) begin
        active_state   <= ns_n;
        active_type    <= nt_n;
        interval_start <= now_t;
      end
      if (ram_we) begin
        vld[s1.addr] <= 1'b1;
        fw_v         <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      s1 <= s0;
    end
    if (ram_we) begin
      fw_addr <= s1.addr;
      fw_data <= ram_wdata;
    end
    if (s1_adv) begin
      result.recorded            <= (s1.op == OP_RECORD);
      result.closed_state        <= s1.closed_state;
      result.closed_type         <= s1.closed_type;
      result.duration            <= DUR_W'(s1.dur);
      result.entry_compute_count <= COUNT_W'(report.comp_count);
      result.entry_compute_time  <= DUR_W'(report.comp_time);
      result.entry_wait_count    <= COUNT_W'(report.wait_count);
      result.entry_wait_time     <= DUR_W'(report.wait_time);
      result.current_state       <= s1.cur_state;
      result.current_type        <= s1.cur_type;
    end
  end

  assign result.valid = res_v;

  // checks
  `SRP_ASSERT(a_ready_when_empty, !s1_v |-> item.ready, "input blocked with empty stage")
  `SRP_ASSERT(a_stage_holds, s1_v && !s1_adv |=> s1_v && $stable(s1), "stalled stage changed")
  `SRP_ASSERT(a_stage_to_result, s1_adv |=> result.valid, "advanced item gave no result beat")
  `SRP_ASSERT(a_row_marked, ram_we |=> vld[$past(s1.addr)], "written row not marked valid")
  `SRP_ASSERT_RST(a_reset_empty, rst |=> !result.valid && !s1_v, "pipeline not empty after reset")

endmodule
